// File: sv/brp_pkg.sv
package brp_pkg;

    localparam int RANGE_W        = 32;
    localparam int IDX_W          = 10;
    localparam int CNT_W          = 11;
    localparam int MAX_PARTS_DEF  = 1024;
    localparam int COORD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_MANY = 2'd1,
        STATUS_BAD_ARGS = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [RANGE_W-1:0] range_low;
        logic signed [RANGE_W-1:0] range_high;
        logic [IDX_W-1:0]          part_index;
        logic [CNT_W-1:0]          part_count;
    } t_in_item;

    typedef struct packed {
        logic signed [RANGE_W-1:0] part_low;
        logic signed [RANGE_W-1:0] part_high;
        t_status                   status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RANGE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_STEP,
        S_FIRST,
        S_LAST,
        S_DONE
    } t_state;

endpackage

// File: sv/brp_serial_div.sv
module brp_serial_div #(
    parameter int WW = brp_pkg::COORD_BITS_DEF + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [WW-1:0]             i_dividend,
    input  logic [brp_pkg::CNT_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [WW-1:0]             o_quotient
);

    localparam int CW_CNT = $clog2(WW + 1);

    logic                      r_busy;
    logic                      n_busy;
    logic                      r_done;
    logic                      n_done;
    logic [CW_CNT-1:0]         r_bits;
    logic [CW_CNT-1:0]         n_bits;
    logic [WW-1:0]             r_sr;
    logic [WW-1:0]             n_sr;
    logic [brp_pkg::CNT_W-1:0] r_rem;
    logic [brp_pkg::CNT_W-1:0] n_rem;
    logic [brp_pkg::CNT_W:0]   w_trial;
    logic [brp_pkg::CNT_W:0]   w_diff;
    logic                      w_qbit;

    // One quotient bit per cycle. The dividend leaves the shift register at the
    // top while quotient bits enter at the bottom; the remainder stays below the
    // divisor, so it is as narrow as the part count.
    always_comb begin
        w_trial = {r_rem, r_sr[WW-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        w_qbit  = (w_trial >= {1'b0, i_divisor});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_bits  = r_bits;
        n_sr    = r_sr;
        n_rem   = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_bits = CW_CNT'(WW);
            n_sr   = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_sr   = {r_sr[WW-2:0], w_qbit};
            n_rem  = w_qbit ? w_diff[brp_pkg::CNT_W-1:0] : w_trial[brp_pkg::CNT_W-1:0];
            n_bits = r_bits - CW_CNT'(1);
            if (r_bits == CW_CNT'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bits <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_bits <= n_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr  <= n_sr;
        r_rem <= n_rem;
    end

    assign o_done     = r_done;
    assign o_quotient = r_sr;

endmodule

// File: sv/block_range_partition_core.sv
// Returns the bounds of one part of an inclusive range split into part_count
// contiguous parts, where part 0 gets floor(W / part_count) values and every
// later part gets the remaining width divided by the parts still left. One item
// is worked on at a time: a bit-serial divider finds each part's share one
// quotient bit per cycle, and part k needs k + 1 divisions. After each division
// but the last, a step updates the offset and the remaining width; after the last
// one, the first and last bounds are formed and the result goes to the output.
// Items with invalid arguments or more parts than values skip the divisions and
// finish with zero bounds. A finished result waits in the output register, so
// the next item can be taken while it is still stalled.
module block_range_partition_core #(
    parameter int MAX_PARTS  = brp_pkg::MAX_PARTS_DEF,
    parameter int COORD_BITS = brp_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  brp_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output brp_pkg::t_out_item  o_out_item
);

    localparam int CW  = COORD_BITS;
    localparam int WW  = CW + 1;
    localparam int XW  = (WW > brp_pkg::RANGE_W) ? WW : brp_pkg::RANGE_W;
    localparam int CMW = (WW > brp_pkg::CNT_W) ? WW : brp_pkg::CNT_W;
    localparam int SB  = (CW <= brp_pkg::RANGE_W) ? CW - 1 : brp_pkg::RANGE_W - 1;
    localparam logic [31:0] MAX_P = 32'(MAX_PARTS);

    brp_pkg::t_state            r_state;
    brp_pkg::t_state            n_state;
    logic [XW-1:0]              r_lo;
    logic [XW-1:0]              r_hi;
    logic [brp_pkg::IDX_W-1:0]  r_idx;
    logic [brp_pkg::CNT_W-1:0]  r_cnt;
    logic [brp_pkg::IDX_W-1:0]  r_i;
    logic [WW-1:0]              r_width;
    logic [WW-1:0]              r_off;
    logic [WW-1:0]              r_share;
    logic [XW-1:0]              r_first;
    brp_pkg::t_out_item         r_res;
    logic                       r_out_valid;
    brp_pkg::t_out_item         r_out;

    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_bad;
    logic                       w_too_many;
    logic [XW-1:0]              w_diff;
    logic [XW-1:0]              w_last;
    logic [brp_pkg::CNT_W-1:0]  w_divisor;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [WW-1:0]              w_div_q;

    // Coordinates are the low COORD_BITS bits of a range field, sign-extended (zero-extended if COORD_BITS > RANGE_W).
    function automatic logic [XW-1:0] f_coord(input logic [brp_pkg::RANGE_W-1:0] raw);
        logic [XW-1:0] ext;
        logic          sgn;
        logic [XW-1:0] v;
        ext = XW'(raw);
        sgn = (CW <= brp_pkg::RANGE_W) ? raw[SB] : 1'b0;
        for (int b = 0; b < XW; b++) begin
            v[b] = (b < CW) ? ext[b] : sgn;
        end
        return v;
    endfunction

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_bad      = ($signed(r_lo) > $signed(r_hi)) || (r_cnt == '0)
                        || (32'(r_cnt) > MAX_P) || (brp_pkg::CNT_W'(r_idx) >= r_cnt);
    assign w_too_many = (CMW'(r_cnt) > CMW'(r_width));
    assign w_diff     = r_hi - r_lo + XW'(1);
    assign w_last     = r_first + XW'(r_share) - XW'(1);
    assign w_divisor  = r_cnt - brp_pkg::CNT_W'(r_i);

    brp_serial_div #(
        .WW(WW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_width),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        o_in_stall  = (r_state != brp_pkg::S_IDLE);
        unique case (r_state)
            brp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = brp_pkg::S_CHECK;
                end
            end
            brp_pkg::S_CHECK: begin
                n_state = w_bad ? brp_pkg::S_DONE : brp_pkg::S_RANGE;
            end
            brp_pkg::S_RANGE: begin
                n_state = w_too_many ? brp_pkg::S_DONE : brp_pkg::S_DIV_GO;
            end
            brp_pkg::S_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = brp_pkg::S_DIV_WAIT;
            end
            brp_pkg::S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_i == r_idx) ? brp_pkg::S_FIRST : brp_pkg::S_STEP;
                end
            end
            brp_pkg::S_STEP: begin
                n_state = brp_pkg::S_DIV_GO;
            end
            brp_pkg::S_FIRST: begin
                n_state = brp_pkg::S_LAST;
            end
            brp_pkg::S_LAST: begin
                n_state = brp_pkg::S_DONE;
            end
            brp_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = brp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = brp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == brp_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lo  <= f_coord(i_in_item.range_low);
            r_hi  <= f_coord(i_in_item.range_high);
            r_idx <= i_in_item.part_index;
            r_cnt <= i_in_item.part_count;
        end
        if (r_state == brp_pkg::S_CHECK) begin
            r_width <= w_diff[WW-1:0];
            if (w_bad) begin
                r_res <= '{part_low: '0, part_high: '0, status: brp_pkg::STATUS_BAD_ARGS};
            end
        end
        if (r_state == brp_pkg::S_RANGE) begin
            r_off <= '0;
            r_i   <= '0;
            if (w_too_many) begin
                r_res <= '{part_low: '0, part_high: '0, status: brp_pkg::STATUS_TOO_MANY};
            end
        end
        if (r_state == brp_pkg::S_DIV_WAIT && w_div_done) begin
            r_share <= w_div_q;
        end
        if (r_state == brp_pkg::S_STEP) begin
            r_off   <= r_off + r_share;
            r_width <= r_width - r_share;
            r_i     <= r_i + brp_pkg::IDX_W'(1);
        end
        if (r_state == brp_pkg::S_FIRST) begin
            r_first <= r_lo + XW'(r_off);
        end
        if (r_state == brp_pkg::S_LAST) begin
            r_res <= '{part_low:  r_first[brp_pkg::RANGE_W-1:0],
                       part_high: w_last[brp_pkg::RANGE_W-1:0],
                       status:    brp_pkg::STATUS_OK};
        end
        if (r_state == brp_pkg::S_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: sv/brp_checker.sv
module brp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input brp_pkg::t_out_item o_out_item
);

    // Only one item is in work at a time, so taking one closes the input.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in work");

    // A new result only appears when an item has just been finished.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no item in work");

    // Error results carry zero bounds.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != brp_pkg::STATUS_OK))
        |-> (o_out_item.part_low == '0) && (o_out_item.part_high == '0))
        else $error("error result with nonzero bounds");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed or dropped");

endmodule

bind block_range_partition_core brp_checker u_brp_checker (.*);
